// File: hdl/top_peaks_per_bin_filter_unit_defines.svh
// ----------------------------------------------------------------------------
// top_peaks_per_bin_filter_unit_defines
// Assertion macros used by the peak filter datapath.
// ----------------------------------------------------------------------------
`ifndef TOP_PEAKS_PER_BIN_FILTER_UNIT_DEFINES_SVH
`define TOP_PEAKS_PER_BIN_FILTER_UNIT_DEFINES_SVH

// property that holds on every enabled clock edge
`define PPBF_ASSERT_HOLDS(label, p_clk, p_rst, expr, msg) \
  label: assert property (@(posedge p_clk) disable iff (p_rst) (expr)) \
    else $error(msg);

// same-cycle implication
`define PPBF_ASSERT_IMPLIES(label, p_clk, p_rst, ante, cons, msg) \
  label: assert property (@(posedge p_clk) disable iff (p_rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPBF_ASSERT_NEXT(label, p_clk, p_rst, ante, cons, msg) \
  label: assert property (@(posedge p_clk) disable iff (p_rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ppbf_pkg.sv
// ----------------------------------------------------------------------------
// ppbf_pkg
// Constants and controller/datapath interface types of the peak filter.
// ----------------------------------------------------------------------------
package ppbf_pkg;

  // list depth and field widths
  localparam int TOP_COUNT = 6;
  localparam int MZ_W      = 32;
  localparam int INT_W     = 32;
  localparam int RANK_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int DIV_CNT_W = $clog2(MZ_W);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_LIMIT = 1'b1;

  // configuration reset values
  localparam logic [MZ_W-1:0]  BIN_WIDTH_RST       = 32'd6553600;
  localparam logic [INT_W-1:0] INTENSITY_LIMIT_RST = 32'd80;

  // input item kinds
  localparam logic CMD_PEAK = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic div_step;
    logic update_bin;
    logic emit_load;
    logic insert;
    logic spectrum_reset;
  } ctrl_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic in_end;
    logic item_end;
    logic origin_set;
    logic list_nonempty;
    logic bin_changed;
    logic div_last;
    logic out_free;
    logic emit_last;
  } ctrl_sts_t;

endpackage

// File: hdl/top_peaks_per_bin_filter_unit.sv
// ----------------------------------------------------------------------------
// top_peaks_per_bin_filter_unit
// Per-bin top-k peak selector with ranked flush on bin change or end item.
// ----------------------------------------------------------------------------
// A peak item passes from acceptance through the 32-step serial divider that
// finds the bin index, a flush of the kept results when the bin changes (held
// while out_stall holds the output register) and the insert into the list.
// An end item flushes the kept results, if any, and clears the spectrum. Items
// are worked one at a time; the output register lets a finished transaction
// wait while the next item is taken. Configuration writes are taken at any
// time and must only be made while the block is idle.
module top_peaks_per_bin_filter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ppbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppbf_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [ppbf_pkg::MZ_W-1:0]       peak_mz,
  input  logic [ppbf_pkg::INT_W-1:0]      peak_intensity,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ppbf_pkg::MZ_W-1:0]       out_mz,
  output logic [ppbf_pkg::RANK_W-1:0]     rank_score,
  output logic                            last,
  output logic                            spectrum_end
);

  ppbf_pkg::ctrl_cmd_t ctl;
  ppbf_pkg::ctrl_sts_t sts;

  // sequencer
  ppbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath
  ppbf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .peak_mz        (peak_mz),
    .peak_intensity (peak_intensity),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_mz         (out_mz),
    .rank_score     (rank_score),
    .last           (last),
    .spectrum_end   (spectrum_end)
  );

endmodule

// File: hdl/ppbf_datapath.sv
// ----------------------------------------------------------------------------
// ppbf_datapath
// Config registers, serial bin divider, sorted top list and output register.
// ----------------------------------------------------------------------------
`include "top_peaks_per_bin_filter_unit_defines.svh"

module ppbf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ppbf_pkg::ctrl_cmd_t                ctl,
  output ppbf_pkg::ctrl_sts_t                sts,
  input  logic                               cfg_we,
  input  logic [ppbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppbf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               cmd,
  input  logic [ppbf_pkg::MZ_W-1:0]          peak_mz,
  input  logic [ppbf_pkg::INT_W-1:0]         peak_intensity,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [ppbf_pkg::MZ_W-1:0]          out_mz,
  output logic [ppbf_pkg::RANK_W-1:0]        rank_score,
  output logic                               last,
  output logic                               spectrum_end
);

  // configuration
  logic [ppbf_pkg::MZ_W-1:0]  bin_width;
  logic [ppbf_pkg::INT_W-1:0] intensity_limit;

  // spectrum state
  logic                       origin_set;
  logic [ppbf_pkg::MZ_W-1:0]  origin_mz;
  logic [ppbf_pkg::MZ_W-1:0]  current_bin;

  // item registers
  logic                       item_end;
  logic [ppbf_pkg::MZ_W-1:0]  item_mz;
  logic [ppbf_pkg::INT_W-1:0] item_int;
  logic [ppbf_pkg::RANK_W-1:0] rank_cnt;

  // divider
  logic [ppbf_pkg::MZ_W-1:0]      div_rem;
  logic [ppbf_pkg::MZ_W-1:0]      div_quo;
  logic [ppbf_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [ppbf_pkg::MZ_W+1:0]      div_trial;
  logic [ppbf_pkg::MZ_W-1:0]      mz_diff;

  // kept list, entry 0 is the most intense
  logic [ppbf_pkg::MZ_W-1:0]  kept_mz  [ppbf_pkg::TOP_COUNT];
  logic [ppbf_pkg::INT_W-1:0] kept_int [ppbf_pkg::TOP_COUNT];
  logic [ppbf_pkg::TOP_COUNT-1:0] kept_valid;
  logic [ppbf_pkg::TOP_COUNT-1:0] valid_up;
  logic [ppbf_pkg::TOP_COUNT-1:0] take_new;
  logic [ppbf_pkg::TOP_COUNT-1:0] take_prev;
  logic                           qualify;
  logic                           clear_list;
  logic                           first_peak;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_width       <= ppbf_pkg::BIN_WIDTH_RST;
      intensity_limit <= ppbf_pkg::INTENSITY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppbf_pkg::CFG_BIN_WIDTH:       bin_width       <= cfg_data;
        ppbf_pkg::CFG_INTENSITY_LIMIT: intensity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign first_peak = ctl.load_item && (cmd == ppbf_pkg::CMD_PEAK) && !origin_set;
  assign clear_list = ctl.spectrum_reset || first_peak;

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item_end <= (cmd == ppbf_pkg::CMD_END);
      item_mz  <= peak_mz;
      item_int <= peak_intensity;
      rank_cnt <= ppbf_pkg::RANK_W'(ppbf_pkg::TOP_COUNT);
    end else if (ctl.emit_load) begin
      rank_cnt <= rank_cnt - 1'b1;
    end
  end

  // origin and current bin
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_set  <= 1'b0;
      origin_mz   <= '0;
      current_bin <= '0;
    end else if (ctl.spectrum_reset) begin
      origin_set  <= 1'b0;
      current_bin <= '0;
    end else begin
      if (first_peak) begin
        origin_set  <= 1'b1;
        origin_mz   <= peak_mz;
        current_bin <= '0;
      end
      if (ctl.update_bin) begin
        current_bin <= div_quo;
      end
    end
  end

  // distance from origin, saturated at zero
  assign mz_diff = (item_mz >= origin_mz) ? (item_mz - origin_mz) : '0;

  // restoring divider, one quotient bit per cycle
  assign div_trial = {1'b0, div_rem, div_quo[ppbf_pkg::MZ_W-1]} - {2'b00, bin_width};

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      div_rem <= '0;
      div_quo <= mz_diff;
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!div_trial[ppbf_pkg::MZ_W+1]) begin
        div_rem <= div_trial[ppbf_pkg::MZ_W-1:0];
        div_quo <= {div_quo[ppbf_pkg::MZ_W-2:0], 1'b1};
      end else begin
        div_rem <= {div_rem[ppbf_pkg::MZ_W-2:0], div_quo[ppbf_pkg::MZ_W-1]};
        div_quo <= {div_quo[ppbf_pkg::MZ_W-2:0], 1'b0};
      end
    end
  end

  // insert position: first slot that is empty or weaker
  always_comb begin
    logic above;
    above     = 1'b0;
    take_new  = '0;
    take_prev = '0;
    for (int b = 0; b < ppbf_pkg::TOP_COUNT; b++) begin
      take_prev[b] = above;
      if (!above && (!kept_valid[b] || (item_int > kept_int[b]))) begin
        take_new[b] = 1'b1;
        above       = 1'b1;
      end
    end
  end

  assign qualify  = item_int > intensity_limit;
  assign valid_up = kept_valid >> 1;

  // valid bits of the list
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_valid <= '0;
    end else if (clear_list) begin
      kept_valid <= '0;
    end else if (ctl.emit_load) begin
      kept_valid <= valid_up;
    end else if (ctl.insert && qualify) begin
      for (int c = 0; c < ppbf_pkg::TOP_COUNT; c++) begin
        if (take_new[c]) kept_valid[c] <= 1'b1;
      end
      for (int c = 1; c < ppbf_pkg::TOP_COUNT; c++) begin
        if (take_prev[c]) kept_valid[c] <= kept_valid[c-1];
      end
    end
  end

  // list payload: shift out on emit, shift down on insert
  always_ff @(posedge clk) begin
    if (ctl.emit_load) begin
      for (int c = 0; c < ppbf_pkg::TOP_COUNT - 1; c++) begin
        kept_mz[c]  <= kept_mz[c+1];
        kept_int[c] <= kept_int[c+1];
      end
    end else if (ctl.insert && qualify) begin
      for (int c = 0; c < ppbf_pkg::TOP_COUNT; c++) begin
        if (take_new[c]) begin
          kept_mz[c]  <= item_mz;
          kept_int[c] <= item_int;
        end
      end
      for (int c = 1; c < ppbf_pkg::TOP_COUNT; c++) begin
        if (take_prev[c]) begin
          kept_mz[c]  <= kept_mz[c-1];
          kept_int[c] <= kept_int[c-1];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_load) begin
      out_mz       <= kept_mz[0];
      rank_score   <= rank_cnt;
      last         <= !valid_up[0];
      spectrum_end <= item_end;
    end
  end

  // status
  assign sts.in_end        = (cmd == ppbf_pkg::CMD_END);
  assign sts.item_end      = item_end;
  assign sts.origin_set    = origin_set;
  assign sts.list_nonempty = kept_valid[0];
  assign sts.bin_changed   = (div_quo != current_bin);
  assign sts.div_last      = (div_cnt == '1);
  assign sts.out_free      = !out_valid || !out_stall;
  assign sts.emit_last     = !valid_up[0];

  // checks
  `PPBF_ASSERT_HOLDS(a_valid_packed, clk, rst,
    (kept_valid & (kept_valid + 1'b1)) == '0,
    "kept entries not packed at the low end")
  `PPBF_ASSERT_IMPLIES(a_emit_free, clk, rst, ctl.emit_load,
    !out_valid || !out_stall,
    "result loaded over a pending transaction")
  `PPBF_ASSERT_NEXT(a_reset_clears, clk, rst, ctl.spectrum_reset,
    !origin_set && (kept_valid == '0) && (current_bin == '0),
    "spectrum state not cleared at end")

endmodule

// File: hdl/ppbf_ctrl.sv
// ----------------------------------------------------------------------------
// ppbf_ctrl
// Sequencer: item intake, bin division, flush of the kept list, insert.
// ----------------------------------------------------------------------------
module ppbf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppbf_pkg::ctrl_sts_t sts,
  output ppbf_pkg::ctrl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_CHECK,
    S_EMIT,
    S_INSERT
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          if (sts.in_end) begin
            if (sts.list_nonempty) begin
              state_next = S_EMIT;
            end else begin
              ctl.spectrum_reset = 1'b1;
            end
          end else begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        ctl.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        ctl.update_bin = 1'b1;
        if (sts.bin_changed && sts.list_nonempty) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_load = 1'b1;
          if (sts.emit_last) begin
            if (sts.item_end) begin
              ctl.spectrum_reset = 1'b1;
              state_next         = S_IDLE;
            end else begin
              state_next = S_INSERT;
            end
          end
        end
      end
      S_INSERT: begin
        ctl.insert = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered stall
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-bin top-k peak filter.
// A queue of peak and end transactions feeds a falling-edge driver; a
// rising-edge monitor runs a bin/rank predictor on every accepted input
// transaction and compares each output transaction against the oldest
// ranked peak it produced. Several bin width and threshold settings are run,
// with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic                       kind;
    logic [ppbf_pkg::MZ_W-1:0]  mz;
    logic [ppbf_pkg::INT_W-1:0] inten;
  } peak_item_t;

  typedef struct packed {
    logic [ppbf_pkg::MZ_W-1:0]   mz;
    logic [ppbf_pkg::RANK_W-1:0] rank;
    logic                        run_last;
    logic                        run_end;
  } ranked_peak_t;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;

  // clock, reset and block ports
  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [ppbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ppbf_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           cmd = ppbf_pkg::CMD_PEAK;
  logic [ppbf_pkg::MZ_W-1:0]      peak_mz = '0;
  logic [ppbf_pkg::INT_W-1:0]     peak_intensity = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ppbf_pkg::MZ_W-1:0]      out_mz;
  logic [ppbf_pkg::RANK_W-1:0]    rank_score;
  logic                           last;
  logic                           spectrum_end;

  // stimulus and checking state
  peak_item_t   peak_q[$];
  ranked_peak_t ranked_q[$];
  logic         in_taken = 1'b0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_req = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;
  int           mismatch_cnt = 0;

  // predictor copy of the block state and registers
  logic [ppbf_pkg::MZ_W-1:0]  bw_cfg = ppbf_pkg::BIN_WIDTH_RST;
  logic [ppbf_pkg::INT_W-1:0] thr_cfg = ppbf_pkg::INTENSITY_LIMIT_RST;
  logic [ppbf_pkg::MZ_W-1:0]  kept_mz[ppbf_pkg::TOP_COUNT];
  logic [ppbf_pkg::INT_W-1:0] kept_int[ppbf_pkg::TOP_COUNT];
  int                         kept_n = 0;
  logic [ppbf_pkg::MZ_W-1:0]  org_mz = '0;
  logic                       org_set = 1'b0;
  logic [ppbf_pkg::MZ_W-1:0]  cur_bin = '0;

  top_peaks_per_bin_filter_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .peak_mz        (peak_mz),
    .peak_intensity (peak_intensity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mz         (out_mz),
    .rank_score     (rank_score),
    .last           (last),
    .spectrum_end   (spectrum_end)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ranked run of the kept list, strongest first
  task automatic flush_ranked_run(logic run_end);
    ranked_peak_t rp;
    for (int a = 0; a < kept_n; a++) begin
      rp.mz       = kept_mz[a];
      rp.rank     = ppbf_pkg::RANK_W'(ppbf_pkg::TOP_COUNT - a);
      rp.run_last = (a == kept_n - 1);
      rp.run_end  = run_end;
      ranked_q    = {ranked_q, rp};
    end
  endtask

  // bin tracking and top-k insertion for one accepted transaction
  task automatic bin_peak_update(peak_item_t it);
    logic [ppbf_pkg::MZ_W-1:0] diff;
    logic [ppbf_pkg::MZ_W-1:0] bin;
    int                        pos;
    if (it.kind == ppbf_pkg::CMD_END) begin
      if (org_set) flush_ranked_run(1'b1);
      kept_n  = 0;
      org_set = 1'b0;
      cur_bin = '0;
    end else begin
      if (!org_set) begin
        org_mz  = it.mz;
        org_set = 1'b1;
        cur_bin = '0;
        kept_n  = 0;
      end
      diff = (it.mz >= org_mz) ? it.mz - org_mz : '0;
      bin  = (bw_cfg == '0) ? '1 : diff / bw_cfg;
      if (bin != cur_bin) begin
        flush_ranked_run(1'b0);
        kept_n  = 0;
        cur_bin = bin;
      end
      // equal intensity goes behind the earlier peak
      if (it.inten > thr_cfg) begin
        pos = 0;
        while (pos < kept_n && it.inten <= kept_int[pos]) pos++;
        if (pos < ppbf_pkg::TOP_COUNT) begin
          for (int k = ppbf_pkg::TOP_COUNT - 1; k > pos; k--) begin
            kept_mz[k]  = kept_mz[k-1];
            kept_int[k] = kept_int[k-1];
          end
          kept_mz[pos]  = it.mz;
          kept_int[pos] = it.inten;
          if (kept_n < ppbf_pkg::TOP_COUNT) kept_n++;
        end
      end
    end
  endtask

  // input driver, new transaction only when the previous one was taken
  always @(negedge clk) begin
    peak_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (peak_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = peak_q.pop_front();
        in_valid       <= 1'b1;
        cmd            <= it.kind;
        peak_mz        <= it.mz;
        peak_intensity <= it.inten;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: one long hold-off on request, random otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: register writes, input prediction, output checks
  always @(posedge clk) begin
    peak_item_t   it;
    ranked_peak_t rp;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          ppbf_pkg::CFG_BIN_WIDTH:       bw_cfg = cfg_data;
          ppbf_pkg::CFG_INTENSITY_LIMIT: thr_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        it.kind  = cmd;
        it.mz    = peak_mz;
        it.inten = peak_intensity;
        bin_peak_update(it);
      end
      if (out_valid && !out_stall) begin
        if (ranked_q.size() == 0) begin
          $error("unexpected output transaction: out_mz %h rank_score %0d",
                 out_mz, rank_score);
          mismatch_cnt++;
        end else begin
          rp = ranked_q.pop_front();
          if (out_mz !== rp.mz) begin
            $error("out_mz: expected %h, got %h", rp.mz, out_mz);
            mismatch_cnt++;
          end
          if (rank_score !== rp.rank) begin
            $error("rank_score: expected %0d, got %0d", rp.rank, rank_score);
            mismatch_cnt++;
          end
          if (last !== rp.run_last) begin
            $error("last: expected %b, got %b", rp.run_last, last);
            mismatch_cnt++;
          end
          if (spectrum_end !== rp.run_end) begin
            $error("spectrum_end: expected %b, got %b", rp.run_end, spectrum_end);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  task automatic push_item(logic kind, logic [ppbf_pkg::MZ_W-1:0] mz,
                           logic [ppbf_pkg::INT_W-1:0] inten);
    peak_item_t it;
    it.kind  = kind;
    it.mz    = mz;
    it.inten = inten;
    peak_q   = {peak_q, it};
  endtask

  task automatic write_reg(logic [ppbf_pkg::CFG_IDX_W-1:0] idx,
                           logic [ppbf_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every transaction is taken and every result has come out
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (peak_q.size() != 0 || (in_valid && !in_taken) || ranked_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // spectra with ascending m/z and intensities around the threshold,
  // mixed with out-of-order peaks, missing end items and stray end items
  task automatic gen_spectra(int n_items, int unsigned step_max,
                             logic [ppbf_pkg::INT_W-1:0] thr);
    logic [ppbf_pkg::MZ_W-1:0]  mz;
    logic [ppbf_pkg::INT_W-1:0] inten;
    int                         cnt;
    int                         len;
    cnt = 0;
    while (cnt < n_items) begin
      len = $urandom_range(1, 14);
      mz  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0FFF_FFFF);
      for (int p = 0; p < len; p++) begin
        if ($urandom_range(7) == 0) inten = $urandom;
        else inten = ((thr > 20) ? thr - 20 : '0) + $urandom_range(0, 60);
        if ($urandom_range(9) == 0) begin
          push_item(ppbf_pkg::CMD_PEAK, $urandom, inten);
        end else begin
          push_item(ppbf_pkg::CMD_PEAK, mz, inten);
          mz = mz + $urandom_range(0, step_max);
        end
        cnt++;
      end
      if ($urandom_range(11) != 0) begin
        push_item(ppbf_pkg::CMD_END, $urandom, $urandom);
        cnt++;
      end
      if ($urandom_range(15) == 0) begin
        push_item(ppbf_pkg::CMD_END, $urandom, $urandom);
        cnt++;
      end
    end
  endtask

  // run time limit
  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // main sequence
  initial begin
    logic [ppbf_pkg::MZ_W-1:0] o;
    o = 32'h03E8_0000;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 77;

    // directed part at reset settings (100 Da bins, threshold 80)
    push_item(ppbf_pkg::CMD_END, '1, '1);                  // end with no spectrum open
    push_item(ppbf_pkg::CMD_PEAK, o, 81);                  // first peak sets origin
    push_item(ppbf_pkg::CMD_PEAK, o + 1, 80);              // equal to threshold, dropped
    push_item(ppbf_pkg::CMD_PEAK, o + 2, '1);
    push_item(ppbf_pkg::CMD_PEAK, o + 3, 200);
    push_item(ppbf_pkg::CMD_PEAK, o + 4, 200);             // tie keeps arrival order
    push_item(ppbf_pkg::CMD_PEAK, o + 5, 100);
    push_item(ppbf_pkg::CMD_PEAK, o + 6, 300);             // list now full
    push_item(ppbf_pkg::CMD_PEAK, o + 7, 90);              // weakest falls off
    push_item(ppbf_pkg::CMD_PEAK, o + 8, 90);              // ties weakest of full list
    push_item(ppbf_pkg::CMD_PEAK, 32'h0, 500);             // below origin, bin zero
    push_item(ppbf_pkg::CMD_PEAK, o + 32'h0064_0000, 81);  // next bin, full run out
    push_item(ppbf_pkg::CMD_PEAK, o + 32'h0064_0005, 50);
    push_item(ppbf_pkg::CMD_PEAK, '1, 1000);               // far bin
    push_item(ppbf_pkg::CMD_PEAK, o + 32'h0096_0000, 400); // smaller bin again
    push_item(ppbf_pkg::CMD_END, 32'h0, 32'h0);            // run marked spectrum end
    push_item(ppbf_pkg::CMD_PEAK, 32'h0, 32'h0);
    push_item(ppbf_pkg::CMD_PEAK, 32'h00C8_0000, 10);      // bin change, empty run
    push_item(ppbf_pkg::CMD_END, 32'h5555_5555, 32'hAAAA_AAAA);
    push_item(ppbf_pkg::CMD_END, 32'hAAAA_AAAA, 32'h5555_5555);
    push_item(ppbf_pkg::CMD_PEAK, 32'h1234_5678, 32'h8000_0000);
    push_item(ppbf_pkg::CMD_END, 32'h0, 32'h0);
    wait_idle();

    // 10 Da bins
    write_reg(ppbf_pkg::CFG_BIN_WIDTH, 32'd655360);
    gen_spectra(40, 400000, 80);
    wait_idle();

    // narrowest bins, no threshold
    write_reg(ppbf_pkg::CFG_BIN_WIDTH, 32'd1);
    write_reg(ppbf_pkg::CFG_INTENSITY_LIMIT, 32'd0);
    gen_spectra(30, 2, 0);
    wait_idle();

    // widest bins, highest threshold keeps nothing
    send_idle_pct = 77;
    recv_idle_pct = 38;
    write_reg(ppbf_pkg::CFG_BIN_WIDTH, 32'hFFFF_FFFF);
    write_reg(ppbf_pkg::CFG_INTENSITY_LIMIT, 32'hFFFF_FFFF);
    gen_spectra(15, 32'h1000_0000, 32'hFFFF_FFFF);
    wait_idle();

    // zero bin width gives the all-ones bin
    write_reg(ppbf_pkg::CFG_BIN_WIDTH, 32'd0);
    write_reg(ppbf_pkg::CFG_INTENSITY_LIMIT, 32'd1000);
    gen_spectra(30, 100000, 1000);
    wait_idle();

    // no idling, long output hold-off fills the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(ppbf_pkg::CFG_BIN_WIDTH, 32'd3276800);
    write_reg(ppbf_pkg::CFG_INTENSITY_LIMIT, 32'd80);
    gen_spectra(70, 2000000, 80);
    hold_req = 1'b1;
    wait_idle();

    if (ranked_q.size() != 0) begin
      $error("%0d ranked peaks never came out", ranked_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ppbf_pkg.sv
hdl/ppbf_datapath.sv
hdl/ppbf_ctrl.sv
hdl/top_peaks_per_bin_filter_unit.sv
dv/tb_top.sv
